// ===== rtl/core/rle_scanline_decoder_core_macros.svh =====
// assertion macros for the scanline decoder checker
`ifndef RLE_SCANLINE_DECODER_CORE_MACROS_SVH
`define RLE_SCANLINE_DECODER_CORE_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define RLESD_ASSERT_CLK(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// concurrent assertion on clk and rst of the enclosing scope
`define RLESD_ASSERT(name, prop, msg) \
  `RLESD_ASSERT_CLK(name, clk, rst, prop, msg)

`endif

// ===== rtl/core/rlesd_pkg.sv =====
// types and constants of the scanline decoder
`timescale 1ns / 1ps

package rlesd_pkg;

  localparam int LEN_W = 20;
  localparam int COL_W = 13;
  localparam int OUT_COL_W = 12;
  localparam int SAMPLE_W = 16;
  localparam int RUN_W = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [COL_W-1:0] MAX_WIDTH = 13'd4096;
  localparam logic [OUT_COL_W-1:0] COL_SAT = 12'hFFF;

  localparam int LITERAL_BIT = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCANLINE_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_SAMPLES = 1'b1;

  localparam logic ACTION_START = 1'b0;

  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 4;

  typedef struct packed {
    logic             is_start;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] compressed_length;
  } cmd_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] start_column;
    logic [SAMPLE_W-1:0]  sample;
    logic [COL_W-1:0]     run_length;
    logic                 line_done;
    logic                 line_error;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_push_t;

  typedef struct packed {
    logic [COL_W-1:0] width;
    logic             wide;
  } cfg_t;

  function automatic res_t make_res(input logic [COL_W-1:0] col,
                                    input logic [SAMPLE_W-1:0] value,
                                    input logic [COL_W-1:0] len,
                                    input logic done,
                                    input logic err);
    res_t r;
    r.start_column = col[COL_W-1] ? COL_SAT : col[OUT_COL_W-1:0];
    r.sample = value;
    r.run_length = len;
    r.line_done = done;
    r.line_error = err;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] pad_len(input logic [COL_W-1:0] w,
                                               input logic [COL_W-1:0] col);
    return (w > col) ? w - col : '0;
  endfunction

endpackage

// ===== rtl/core/rlesd_item_if.sv =====
// input channel carrying scanline starts and compressed bytes
`timescale 1ns / 1ps

interface rlesd_item_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [7:0]                 data_byte;
  logic [rlesd_pkg::LEN_W-1:0] compressed_length;

  modport source (output valid, output action, output data_byte, output compressed_length,
                  input ready);
  modport sink (input valid, input action, input data_byte, input compressed_length,
                output ready);
endinterface

// ===== rtl/core/rlesd_run_if.sv =====
// output channel carrying decoded runs
`timescale 1ns / 1ps

interface rlesd_run_if;
  logic                           valid;
  logic                           ready;
  logic [rlesd_pkg::OUT_COL_W-1:0] start_column;
  logic [rlesd_pkg::SAMPLE_W-1:0]  sample;
  logic [rlesd_pkg::COL_W-1:0]     run_length;
  logic                           line_done;
  logic                           line_error;

  modport source (output valid, output start_column, output sample, output run_length,
                  output line_done, output line_error, input ready);
  modport sink (input valid, input start_column, input sample, input run_length,
                input line_done, input line_error, output ready);
endinterface

// ===== rtl/core/rle_scanline_decoder_core.sv =====
// scanline run-length decoder, top level
// path: command queue, decode step, result queue; a full result queue stalls decoding
// throughput: one item per cycle, each decoded in turn while the result queue has room
// an item that yields two runs queues both; the single-run output port sends them in turn
// reset clears both queues and the line state; width returns to 1, samples to one byte
`timescale 1ns / 1ps

module rle_scanline_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rlesd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rlesd_pkg::CFG_DATA_W-1:0]    cfg_data,
  rlesd_item_if.sink                          items,
  rlesd_run_if.source                         results
);

  logic [rlesd_pkg::COL_W-1:0] scanline_width;
  logic                        wide_samples;
  rlesd_pkg::cfg_t             cfg;
  logic                        cmd_valid;
  rlesd_pkg::cmd_t             cmd;
  logic                        cmd_pop;
  logic                        space_ok;
  rlesd_pkg::res_push_t        push;

  always_ff @(posedge clk) begin
    if (rst) begin
      scanline_width <= rlesd_pkg::COL_W'(1);
      wide_samples <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        rlesd_pkg::CFG_SCANLINE_WIDTH: begin
          scanline_width <= cfg_data[rlesd_pkg::COL_W-1:0];
        end
        rlesd_pkg::CFG_WIDE_SAMPLES: begin
          wide_samples <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width = (scanline_width > rlesd_pkg::MAX_WIDTH) ? rlesd_pkg::MAX_WIDTH
                                                       : scanline_width;
    cfg.wide = wide_samples;
  end

  rlesd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rlesd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .space_ok  (space_ok),
    .push      (push)
  );

  rlesd_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .results  (results)
  );

endmodule

// ===== rtl/core/rlesd_front.sv =====
// input side: classifies items and queues them for the decoder
`timescale 1ns / 1ps

module rlesd_front (
  input  logic               clk,
  input  logic               rst,
  rlesd_item_if.sink         items,
  output logic               cmd_valid,
  output rlesd_pkg::cmd_t    cmd,
  input  logic               cmd_pop
);

  localparam int PTR_W = $clog2(rlesd_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(rlesd_pkg::CMDQ_DEPTH + 1);

  rlesd_pkg::cmd_t mem [rlesd_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  rlesd_pkg::cmd_t  incoming;

  assign items.ready = (count != CNT_W'(rlesd_pkg::CMDQ_DEPTH));
  assign push = items.valid && items.ready;

  always_comb begin
    incoming.is_start = (items.action == rlesd_pkg::ACTION_START);
    incoming.data_byte = items.data_byte;
    incoming.compressed_length = items.compressed_length;
  end

  assign cmd_valid = (count != '0);
  assign cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(cmd_pop);
    end
  end

endmodule

// ===== rtl/core/rlesd_back.sv =====
// decode side: scanline state and run generation
`timescale 1ns / 1ps

module rlesd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rlesd_pkg::cfg_t       cfg,
  input  logic                  cmd_valid,
  input  rlesd_pkg::cmd_t       cmd,
  output logic                  cmd_pop,
  input  logic                  space_ok,
  output rlesd_pkg::res_push_t  push
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CTRL_HI = 3'd1;
  localparam logic [2:0] PH_CTRL    = 3'd2;
  localparam logic [2:0] PH_LIT_HI  = 3'd3;
  localparam logic [2:0] PH_LIT     = 3'd4;
  localparam logic [2:0] PH_REP_HI  = 3'd5;
  localparam logic [2:0] PH_REP     = 3'd6;

  localparam int LEN_W = rlesd_pkg::LEN_W;
  localparam int COL_W = rlesd_pkg::COL_W;
  localparam int RUN_W = rlesd_pkg::RUN_W;

  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] src_left, src_left_next;
  logic [COL_W-1:0] dest_col, dest_col_next;
  logic [RUN_W-1:0] run_left, run_left_next;
  logic [7:0]       high_hold, high_hold_next;
  logic             closed, closed_next;

  logic                         fire;
  logic [LEN_W-1:0]             src_dec;
  logic [RUN_W-1:0]             count;
  logic [RUN_W-1:0]             run_dec;
  logic [7:0]                   lit_need;
  logic [COL_W-1:0]             dest_count;
  logic [COL_W-1:0]             dest_one;
  logic [COL_W-1:0]             dest_rep;
  logic [rlesd_pkg::SAMPLE_W-1:0] value;
  logic [2:0]                   ctrl_phase;
  logic                         unit_ok_dec;
  logic                         unit_ok_len;

  assign fire = cmd_valid && space_ok;
  assign cmd_pop = fire;

  always_comb begin
    src_dec = (src_left != '0) ? src_left - 1'b1 : '0;
    count = cmd.data_byte[RUN_W-1:0];
    run_dec = (run_left != '0) ? run_left - 1'b1 : '0;
    lit_need = cfg.wide ? {count, 1'b0} : {1'b0, count};
    dest_count = dest_col + COL_W'(count);
    dest_one = dest_col + 1'b1;
    dest_rep = dest_col + COL_W'(run_left);
    value = cfg.wide ? {high_hold, cmd.data_byte} : {8'd0, cmd.data_byte};
    ctrl_phase = cfg.wide ? PH_CTRL_HI : PH_CTRL;
    unit_ok_dec = cfg.wide ? (src_dec >= LEN_W'(2)) : (src_dec != '0);
    unit_ok_len = cfg.wide ? (cmd.compressed_length >= LEN_W'(2))
                           : (cmd.compressed_length != '0);
  end

  always_comb begin
    phase_next = phase;
    src_left_next = src_left;
    dest_col_next = dest_col;
    run_left_next = run_left;
    high_hold_next = high_hold;
    closed_next = closed;
    push = '0;
    if (fire) begin
      if (cmd.is_start) begin
        src_left_next = cmd.compressed_length;
        dest_col_next = '0;
        run_left_next = '0;
        high_hold_next = '0;
        closed_next = 1'b0;
        if (unit_ok_len && (cfg.width != '0)) begin
          phase_next = ctrl_phase;
        end else begin
          push.count = 2'd1;
          push.first = rlesd_pkg::make_res('0, '0, cfg.width, 1'b1, 1'b0);
          phase_next = PH_IDLE;
          closed_next = 1'b1;
        end
      end else if (!closed) begin
        case (phase)
          PH_CTRL_HI, PH_LIT_HI, PH_REP_HI: begin
            high_hold_next = cmd.data_byte;
            src_left_next = src_dec;
            phase_next = phase + 1'b1;
          end
          PH_CTRL: begin
            src_left_next = src_dec;
            if (count == '0) begin
              push.count = 2'd1;
              push.first = rlesd_pkg::make_res(dest_col, '0,
                  rlesd_pkg::pad_len(cfg.width, dest_col), 1'b1, 1'b0);
              phase_next = PH_IDLE;
              closed_next = 1'b1;
            end else if (cmd.data_byte[rlesd_pkg::LITERAL_BIT]) begin
              if ((LEN_W'(lit_need) > src_dec) || (dest_count > cfg.width)) begin
                push.count = 2'd1;
                push.first = rlesd_pkg::make_res(dest_col, '0, '0, 1'b1, 1'b1);
                phase_next = PH_IDLE;
                closed_next = 1'b1;
              end else begin
                run_left_next = count;
                phase_next = cfg.wide ? PH_LIT_HI : PH_LIT;
              end
            end else begin
              if (!unit_ok_dec || (dest_count > cfg.width)) begin
                push.count = 2'd1;
                push.first = rlesd_pkg::make_res(dest_col, '0, '0, 1'b1, 1'b1);
                phase_next = PH_IDLE;
                closed_next = 1'b1;
              end else begin
                run_left_next = count;
                phase_next = cfg.wide ? PH_REP_HI : PH_REP;
              end
            end
          end
          PH_LIT: begin
            src_left_next = src_dec;
            dest_col_next = dest_one;
            run_left_next = run_dec;
            push.count = 2'd1;
            push.first = rlesd_pkg::make_res(dest_col, value, COL_W'(1), 1'b0, 1'b0);
            if (run_dec != '0) begin
              phase_next = cfg.wide ? PH_LIT_HI : PH_LIT;
            end else if (unit_ok_dec && (dest_one < cfg.width)) begin
              phase_next = ctrl_phase;
            end else begin
              push.count = 2'd2;
              push.second = rlesd_pkg::make_res(dest_one, '0,
                  rlesd_pkg::pad_len(cfg.width, dest_one), 1'b1, 1'b0);
              phase_next = PH_IDLE;
              closed_next = 1'b1;
            end
          end
          PH_REP: begin
            src_left_next = src_dec;
            dest_col_next = dest_rep;
            run_left_next = '0;
            push.count = 2'd1;
            push.first = rlesd_pkg::make_res(dest_col, value, COL_W'(run_left), 1'b0, 1'b0);
            if (unit_ok_dec && (dest_rep < cfg.width)) begin
              phase_next = ctrl_phase;
            end else begin
              push.count = 2'd2;
              push.second = rlesd_pkg::make_res(dest_rep, '0,
                  rlesd_pkg::pad_len(cfg.width, dest_rep), 1'b1, 1'b0);
              phase_next = PH_IDLE;
              closed_next = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            closed_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      src_left <= '0;
      dest_col <= '0;
      run_left <= '0;
      high_hold <= '0;
      closed <= 1'b1;
    end else begin
      phase <= phase_next;
      src_left <= src_left_next;
      dest_col <= dest_col_next;
      run_left <= run_left_next;
      high_hold <= high_hold_next;
      closed <= closed_next;
    end
  end

endmodule

// ===== rtl/core/rlesd_resq.sv =====
// result queue: takes up to two runs a cycle, hands out one while the receiver is ready
`timescale 1ns / 1ps

module rlesd_resq (
  input  logic                 clk,
  input  logic                 rst,
  input  rlesd_pkg::res_push_t push,
  output logic                 space_ok,
  rlesd_run_if.source          results
);

  localparam int PTR_W = $clog2(rlesd_pkg::RESQ_DEPTH);
  localparam int CNT_W = $clog2(rlesd_pkg::RESQ_DEPTH + 1);

  rlesd_pkg::res_t  mem [rlesd_pkg::RESQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_one;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  rlesd_pkg::res_t  head;

  assign wr_ptr_one = wr_ptr + 1'b1;
  assign space_ok = (count <= CNT_W'(rlesd_pkg::RESQ_DEPTH - 2));
  assign pop = results.valid && results.ready;

  assign head = mem[rd_ptr];
  assign results.valid = (count != '0);
  assign results.start_column = head.start_column;
  assign results.sample = head.sample;
  assign results.run_length = head.run_length;
  assign results.line_done = head.line_done;
  assign results.line_error = head.line_error;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_one] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/rlesd_chk.sv =====
// port checker for the scanline decoder and its bind
`timescale 1ns / 1ps
`include "rle_scanline_decoder_core_macros.svh"

module rlesd_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rlesd_pkg::OUT_COL_W-1:0]   start_column,
  input logic [rlesd_pkg::SAMPLE_W-1:0]    sample,
  input logic [rlesd_pkg::COL_W-1:0]       run_length,
  input logic                              line_done,
  input logic                              line_error
);

  `RLESD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "run dropped while stalled")
  `RLESD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(start_column) && $stable(sample) && $stable(run_length) && $stable(line_done) && $stable(line_error), "stalled run changed")
  `RLESD_ASSERT(a_err_shape, out_valid && line_error |-> line_done && (run_length == '0) && (sample == '0), "error run malformed")
  `RLESD_ASSERT(a_data_run_len, out_valid && !line_done |-> run_length != '0, "empty data run")

endmodule

bind rle_scanline_decoder_core rlesd_chk u_rlesd_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .start_column (results.start_column),
  .sample       (results.sample),
  .run_length   (results.run_length),
  .line_done    (results.line_done),
  .line_error   (results.line_error)
);

// ===== bench/rle_scanline_decoder_core_checker.sv =====
// scoreboard for the scanline decoder: predicts runs from observed transfers and compares them
`timescale 1ns / 1ps

module rle_scanline_decoder_core_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rlesd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rlesd_pkg::CFG_DATA_W-1:0]  cfg_data,
  rlesd_item_if                             items,
  rlesd_run_if                              results,
  output int                                failures,
  output int                                pending
);

  localparam int COL_W = rlesd_pkg::COL_W;
  localparam int OUT_COL_W = rlesd_pkg::OUT_COL_W;
  localparam int SAMPLE_W = rlesd_pkg::SAMPLE_W;
  localparam int LEN_W = rlesd_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CTRL_HI, S_CTRL, S_LIT_HI, S_LIT, S_REP_HI, S_REP
  } line_phase_t;

  logic [COL_W-1:0] line_width;
  logic             wide_mode;
  line_phase_t      phase;
  int unsigned      bytes_left;
  int unsigned      next_col;
  int unsigned      lit_left;
  logic [7:0]       held_byte;
  logic             line_shut;
  int               fail_count;

  rlesd_pkg::res_t expected_runs[$];
  rlesd_pkg::res_t got;
  rlesd_pkg::res_t want;

  function automatic int unsigned clamp_width();
    return (line_width > rlesd_pkg::MAX_WIDTH) ? int'(rlesd_pkg::MAX_WIDTH) : int'(line_width);
  endfunction

  task automatic push_run(input int unsigned col, input logic [SAMPLE_W-1:0] value,
                          input int unsigned len, input logic done, input logic err);
    rlesd_pkg::res_t r;
    r.start_column = (col > 4095) ? rlesd_pkg::COL_SAT : OUT_COL_W'(col);
    r.sample = value;
    r.run_length = (len > 8191) ? {COL_W{1'b1}} : COL_W'(len);
    r.line_done = done;
    r.line_error = err;
    expected_runs.push_back(r);
  endtask

  task automatic close_line(input logic err);
    int unsigned w;
    w = clamp_width();
    if (err) begin
      push_run(next_col, '0, 0, 1'b1, 1'b1);
    end else begin
      push_run(next_col, '0, (w > next_col) ? w - next_col : 0, 1'b1, 1'b0);
    end
    phase = S_IDLE;
    line_shut = 1'b1;
  endtask

  task automatic advance_unit();
    int unsigned unit;
    unit = wide_mode ? 2 : 1;
    if (bytes_left >= unit && next_col < clamp_width()) begin
      phase = wide_mode ? S_CTRL_HI : S_CTRL;
    end else begin
      close_line(1'b0);
    end
  endtask

  task automatic predict_item(input logic act, input logic [7:0] b,
                              input logic [LEN_W-1:0] len);
    int unsigned unit;
    int unsigned w;
    int unsigned cnt;
    logic [SAMPLE_W-1:0] value;
    unit = wide_mode ? 2 : 1;
    w = clamp_width();
    if (act == rlesd_pkg::ACTION_START) begin
      bytes_left = len;
      next_col = 0;
      lit_left = 0;
      held_byte = '0;
      line_shut = 1'b0;
      advance_unit();
    end else if (!line_shut) begin
      value = wide_mode ? {held_byte, b} : {8'h00, b};
      if (bytes_left != 0) bytes_left--;
      case (phase)
        S_CTRL_HI, S_LIT_HI, S_REP_HI: begin
          held_byte = b;
          phase = line_phase_t'(phase + 3'd1);
        end
        S_CTRL: begin
          cnt = 32'(b & 8'h7F);
          if (cnt == 0) begin
            close_line(1'b0);
          end else if (b[rlesd_pkg::LITERAL_BIT]) begin
            if (cnt * unit > bytes_left || next_col + cnt > w) begin
              close_line(1'b1);
            end else begin
              lit_left = cnt;
              phase = wide_mode ? S_LIT_HI : S_LIT;
            end
          end else begin
            if (bytes_left < unit || next_col + cnt > w) begin
              close_line(1'b1);
            end else begin
              lit_left = cnt;
              phase = wide_mode ? S_REP_HI : S_REP;
            end
          end
        end
        S_LIT: begin
          push_run(next_col, value, 1, 1'b0, 1'b0);
          next_col++;
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) begin
            advance_unit();
          end else begin
            phase = wide_mode ? S_LIT_HI : S_LIT;
          end
        end
        S_REP: begin
          push_run(next_col, value, lit_left, 1'b0, 1'b0);
          next_col += lit_left;
          lit_left = 0;
          advance_unit();
        end
        default: begin
          phase = S_IDLE;
          line_shut = 1'b1;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_width = 13'd1;
      wide_mode = 1'b0;
      phase = S_IDLE;
      bytes_left = 0;
      next_col = 0;
      lit_left = 0;
      held_byte = '0;
      line_shut = 1'b1;
      fail_count = 0;
      expected_runs.delete();
    end else begin
      if (results.valid && results.ready) begin
        got.start_column = results.start_column;
        got.sample = results.sample;
        got.run_length = results.run_length;
        got.line_done = results.line_done;
        got.line_error = results.line_error;
        if (expected_runs.size() == 0) begin
          fail_count++;
          $display("%0t unexpected run: expected none, got col %0d sample %h len %0d done %b err %b",
                   $time, got.start_column, got.sample, got.run_length, got.line_done,
                   got.line_error);
        end else begin
          want = expected_runs.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t run mismatch: expected col %0d sample %h len %0d done %b err %b, got col %0d sample %h len %0d done %b err %b",
                     $time, want.start_column, want.sample, want.run_length, want.line_done,
                     want.line_error, got.start_column, got.sample, got.run_length,
                     got.line_done, got.line_error);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == rlesd_pkg::CFG_SCANLINE_WIDTH) begin
          line_width = cfg_data;
        end else begin
          wide_mode = cfg_data[0];
        end
      end
      if (items.valid && items.ready) begin
        predict_item(items.action, items.data_byte, items.compressed_length);
      end
    end
    pending <= expected_runs.size();
    failures <= fail_count;
  end

endmodule

// ===== bench/rle_scanline_decoder_core_test.sv =====
// top of the scanline decoder bench: clock, reset, register setup, stimulus and verdict
`timescale 1ns / 1ps

module rle_scanline_decoder_core_test;

  localparam int CFG_INDEX_W = rlesd_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W = rlesd_pkg::CFG_DATA_W;
  localparam int LEN_W = rlesd_pkg::LEN_W;
  localparam logic ACTION_BYTE = ~rlesd_pkg::ACTION_START;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SEGMENTS = 8;
  localparam int SETTLE_CYCLES = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cur_width = 1;
  logic cur_wide = 1'b0;
  int failures;
  int pending;

  int seg_width[SEGMENTS] = '{1, 4096, 24, 8191, 64, 3, 300, 12};
  logic seg_wide[SEGMENTS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  int seg_gap[4] = '{0, 50, 0, 33};
  int seg_stall[4] = '{0, 0, 50, 33};

  rlesd_item_if item_ch();
  rlesd_run_if run_ch();

  rle_scanline_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (item_ch),
    .results  (run_ch)
  );

  rle_scanline_decoder_core_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (item_ch),
    .results  (run_ch),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    run_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      run_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.data_byte <= b;
    item_ch.compressed_length <= len;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_start(input logic [LEN_W-1:0] len);
    send_item(rlesd_pkg::ACTION_START, 8'($urandom), len);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACTION_BYTE, b, LEN_W'($urandom));
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int width, input logic wide);
    cfg_write <= 1'b1;
    cfg_index <= rlesd_pkg::CFG_SCANLINE_WIDTH;
    cfg_data <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_index <= rlesd_pkg::CFG_WIDE_SAMPLES;
    cfg_data <= CFG_DATA_W'(wide);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_width = width;
    cur_wide = wide;
  endtask

  // one mostly well-formed scanline at the current setting, sometimes truncated or broken
  task automatic send_line();
    logic [7:0] line_bytes[$];
    int limit;
    int col;
    int count;
    int kind;
    int len;
    int n_send;
    int lit_share;
    int pick;
    bit ended;
    limit = (cur_width > 4096) ? 4096 : cur_width;
    lit_share = (limit > 256) ? 12 : 50;
    col = 0;
    ended = 0;
    while (!ended && col < limit && line_bytes.size() < 600) begin
      kind = $urandom_range(99);
      if (cur_wide) line_bytes.push_back(8'($urandom));
      if (kind < 4) begin
        line_bytes.push_back({1'($urandom_range(1)), 7'd0});
        ended = 1;
      end else if (kind < 8) begin
        count = limit - col + $urandom_range(4, 1);
        if (count > 127) count = 127;
        line_bytes.push_back({1'($urandom_range(1)), 7'(count)});
        repeat (cur_wide ? 2 : 1) line_bytes.push_back(8'($urandom));
        ended = 1;
      end else if (kind < lit_share) begin
        count = limit - col;
        if (count > 8) count = 8;
        count = $urandom_range(count, 1);
        line_bytes.push_back({1'b1, 7'(count)});
        repeat (count * (cur_wide ? 2 : 1)) line_bytes.push_back(8'($urandom));
        col += count;
      end else begin
        count = limit - col;
        if (count > 127) count = 127;
        count = $urandom_range(count, 1);
        line_bytes.push_back({1'b0, 7'(count)});
        repeat (cur_wide ? 2 : 1) line_bytes.push_back(8'($urandom));
        col += count;
      end
    end
    len = line_bytes.size();
    n_send = line_bytes.size();
    pick = $urandom_range(9);
    if (pick == 0) begin
      len = $urandom_range(line_bytes.size());
    end else if (pick == 1) begin
      count = $urandom_range(3, 1);
      repeat (count) line_bytes.push_back(8'($urandom));
      len = line_bytes.size();
      n_send = line_bytes.size();
    end else if (pick == 2) begin
      n_send = $urandom_range(line_bytes.size());
    end else if (pick == 3) begin
      len = $urandom_range(20'hFFFFF, 0);
    end
    send_start(LEN_W'(len));
    for (int i = 0; i < n_send; i++) send_byte(line_bytes[i]);
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = ACTION_BYTE;
    item_ch.data_byte = '0;
    item_ch.compressed_length = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(8, 1'b0);
    send_start(20'd0);
    send_start(20'hFFFFF);
    send_byte(8'h83);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h05);
    send_byte(8'h7E);
    send_byte(8'h12);
    send_start(20'd2);
    send_byte(8'h02);
    send_byte(8'h33);
    send_start(20'd3);
    send_byte(8'h89);
    send_start(20'd10);
    send_byte(8'h00);
    send_start(20'd5);
    send_byte(8'h81);
    send_start(20'd1);
    send_byte(8'h80);
    wait_drained();
    set_config(0, 1'b0);
    send_start(20'd4);
    wait_drained();
    set_config(4096, 1'b1);
    send_start(20'd6);
    send_byte(8'hFF);
    send_byte(8'h81);
    send_byte(8'hAB);
    send_byte(8'hCD);
    send_byte(8'h00);
    send_byte(8'h7F);

    sent = 0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      set_config(seg_width[seg], seg_wide[seg]);
      gap_pct = seg_gap[seg % 4];
      stall_pct = seg_stall[seg % 4];
      while (sent < (seg + 1) * RANDOM_ITEMS / SEGMENTS) send_line();
    end

    wait_drained();
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rlesd_pkg.sv
rtl/core/rlesd_item_if.sv
rtl/core/rlesd_run_if.sv
rtl/core/rlesd_front.sv
rtl/core/rlesd_back.sv
rtl/core/rlesd_resq.sv
rtl/core/rle_scanline_decoder_core.sv
rtl/core/rlesd_chk.sv
bench/rle_scanline_decoder_core_checker.sv
bench/rle_scanline_decoder_core_test.sv
